@@ hdl/pmg_pkg.sv @@
package pmg_pkg;

  // Configuration register indexes
  localparam logic [2:0] CFG_PRESET   = 3'd0;
  localparam logic [2:0] CFG_STRENGTH = 3'd1;
  localparam logic [2:0] CFG_SEED     = 3'd2;
  localparam logic [2:0] CFG_WIDTH    = 3'd3;
  localparam logic [2:0] CFG_HEIGHT   = 3'd4;

  typedef enum logic [2:0] {
    PRESET_LIN_X   = 3'd0,
    PRESET_LIN_Y   = 3'd1,
    PRESET_RADIAL  = 3'd2,
    PRESET_CHECKER = 3'd3,
    PRESET_NOISE   = 3'd4,
    PRESET_EDGE    = 3'd5,
    PRESET_DIRT    = 3'd6
  } preset_t;

  // Coordinate hash multipliers
  localparam logic [31:0] HASH_MUL_X   = 32'd374761393;
  localparam logic [31:0] HASH_MUL_Y   = 32'd668265263;
  localparam logic [31:0] HASH_MUL_S   = 32'd2246822519;
  localparam logic [31:0] HASH_MUL_MIX = 32'd1274126177;

  localparam logic [16:0] ONE_Q16 = 17'd65536;

  // Mix rounding: (num + 12800) >> 10, then divide by 25 as a reciprocal multiply
  localparam int          MIX_SHIFT = 27;
  localparam logic [22:0] MIX_RECIP = 23'd5368710;

  // Square root unit: 16 result bits, four per stage
  localparam int SQ_STAGES = 4;
  localparam int SQ_STEPS  = 4;

endpackage

@@ hdl/procedural_mask_generator.sv @@
// Channel  Direction  Payload (lowest bit first)           Handshake
// in_      slave      pixel_x[13:0], pixel_y[27:14]        in_tvalid / in_tready
// out_     master     mask_value[7:0]                      out_tvalid / out_tready
// cfg_     slave      cfg_index (register), cfg_data       cfg_valid / cfg_ready
//
// One pixel per clock unless the output stalls. A transaction passes 16 register
// stages: the input register, the coordinate dividers (8 stages), the squares (1),
// the square root (4 stages), the contrast multiply (1) and the byte scaling (1).
// rst_n is synchronous, active low; it clears the valid bits and returns the
// configuration to its defaults.
// The whole pipeline holds while the output register is full and not taken.
module procedural_mask_generator #(
  parameter int COORD_BITS = 14
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // pixel_x[13:0], pixel_y[27:14], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // mask_value[7:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int LAST   = 15;
  localparam int DIV_ST = 8;
  localparam int UN_W   = COORD_BITS + 17;
  localparam int CN_W   = COORD_BITS + 3;

  // ---------------- configuration ----------------
  logic [2:0]  preset_r;
  logic [16:0] strength_r;
  logic [31:0] seed_r;
  logic [14:0] width_r, height_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      preset_r   <= pmg_pkg::PRESET_LIN_X;
      strength_r <= pmg_pkg::ONE_Q16;
      seed_r     <= 32'd0;
      width_r    <= 15'd1024;
      height_r   <= 15'd1024;
    end else if (cfg_valid) begin
      case (cfg_index)
        pmg_pkg::CFG_PRESET:   preset_r   <= cfg_data[2:0];
        pmg_pkg::CFG_STRENGTH: strength_r <= cfg_data[16:0];
        pmg_pkg::CFG_SEED:     seed_r     <= cfg_data;
        pmg_pkg::CFG_WIDTH:    width_r    <= cfg_data[14:0];
        pmg_pkg::CFG_HEIGHT:   height_r   <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  pmg_pkg::preset_t preset;
  assign preset = pmg_pkg::preset_t'(preset_r);

  // Divisors: size-1 for u/v (at least 1), size for checker cells (at least 1)
  logic [14:0] du_den, dv_den, cw_den, ch_den;
  logic [16:0] s_sat;
  assign du_den = (width_r > 15'd1)  ? width_r - 15'd1  : 15'd1;
  assign dv_den = (height_r > 15'd1) ? height_r - 15'd1 : 15'd1;
  assign cw_den = (width_r != 15'd0)  ? width_r  : 15'd1;
  assign ch_den = (height_r != 15'd0) ? height_r : 15'd1;
  assign s_sat  = (strength_r > pmg_pkg::ONE_Q16) ? pmg_pkg::ONE_Q16 : strength_r;

  // ---------------- valid chain and global stall ----------------
  logic [LAST:0] vld_r;
  logic          en;

  assign en        = !vld_r[LAST] || out_tready;
  assign in_tready = en;
  assign out_tvalid = vld_r[LAST];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAST-1:0], in_tvalid};
    end
  end

  // ---------------- stage 0: input register ----------------
  logic [15:0]           x_ext, y_ext;
  logic [COORD_BITS-1:0] x0_r, y0_r;
  assign x_ext = 16'(in_tdata[13:0]);
  assign y_ext = 16'(in_tdata[27:14]);

  always_ff @(posedge clk) begin
    if (en) begin
      x0_r <= x_ext[COORD_BITS-1:0];
      y0_r <= y_ext[COORD_BITS-1:0];
    end
  end

  // ---------------- stages 1..8: dividers and hash ----------------
  logic [UN_W-1:0] u_num, v_num, u_quo, v_quo;
  logic [CN_W-1:0] cx_num, cy_num, cx_quo, cy_quo;

  assign u_num  = UN_W'({x0_r, 16'b0}) + UN_W'(du_den >> 1);
  assign v_num  = UN_W'({y0_r, 16'b0}) + UN_W'(dv_den >> 1);
  assign cx_num = {x0_r, 3'b000};
  assign cy_num = {y0_r, 3'b000};

  pmg_div #(.NUM_W(UN_W), .DEN_W(15), .STAGES(DIV_ST)) u_div_u (
    .clk(clk), .en(en), .num(u_num), .den(du_den), .quo(u_quo));
  pmg_div #(.NUM_W(UN_W), .DEN_W(15), .STAGES(DIV_ST)) u_div_v (
    .clk(clk), .en(en), .num(v_num), .den(dv_den), .quo(v_quo));
  pmg_div #(.NUM_W(CN_W), .DEN_W(15), .STAGES(DIV_ST)) u_div_cx (
    .clk(clk), .en(en), .num(cx_num), .den(cw_den), .quo(cx_quo));
  pmg_div #(.NUM_W(CN_W), .DEN_W(15), .STAGES(DIV_ST)) u_div_cy (
    .clk(clk), .en(en), .num(cy_num), .den(ch_den), .quo(cy_quo));

  logic [23:0] n4;
  logic [23:0] nd_r [4];

  pmg_hash u_hash (
    .clk(clk), .en(en), .x(32'(x0_r)), .y(32'(y0_r)), .seed(seed_r), .n(n4));

  // Delay the noise from stage 4 to line up with the quotients at stage 8
  always_ff @(posedge clk) begin
    if (en) begin
      nd_r[0] <= n4;
      for (int i = 1; i < 4; i++) begin
        nd_r[i] <= nd_r[i-1];
      end
    end
  end

  // ---------------- stage 9: u/v saturate, squares, mix numerator ----------------
  logic [16:0] u8, v8, m_a, m_b, m8, inv_v8;
  logic        par8;
  logic signed [17:0] du8, dv8;
  logic signed [35:0] su8, sv8;
  logic signed [20:0] e8;
  logic signed [33:0] mix8;
  logic [23:0]        n8;

  assign n8   = nd_r[3];
  assign u8   = (u_quo > UN_W'(pmg_pkg::ONE_Q16)) ? pmg_pkg::ONE_Q16 : u_quo[16:0];
  assign v8   = (v_quo > UN_W'(pmg_pkg::ONE_Q16)) ? pmg_pkg::ONE_Q16 : v_quo[16:0];
  assign par8 = cx_quo[0] ^ cy_quo[0];

  assign du8 = $signed({1'b0, u8}) - 18'sd32768;
  assign dv8 = $signed({1'b0, v8}) - 18'sd32768;
  assign su8 = du8 * du8;
  assign sv8 = dv8 * dv8;

  // Edge distance: min of u, v, 1-u, 1-v
  assign inv_v8 = pmg_pkg::ONE_Q16 - v8;
  assign m_a = (u8 < v8) ? u8 : v8;
  assign m_b = ((pmg_pkg::ONE_Q16 - u8) < inv_v8) ? (pmg_pkg::ONE_Q16 - u8) : inv_v8;
  assign m8  = (m_a < m_b) ? m_a : m_b;
  assign e8  = 21'sd65536 - $signed({1'b0, m8, 3'b000});

  // Numerators scaled by 25600: edge (1-8m)*0.75 + n*0.45, m the edge distance; dirt (1-v)*0.65 + n*0.5
  always_comb begin
    case (preset)
      pmg_pkg::PRESET_EDGE:
        mix8 = $signed({{13{e8[20]}}, e8}) * 34'sd19200
             + $signed({10'b0, n8}) * 34'sd45;
      pmg_pkg::PRESET_DIRT:
        mix8 = $signed({17'b0, inv_v8}) * 34'sd16640
             + $signed({10'b0, n8}) * 34'sd50;
      default:
        mix8 = '0;
    endcase
  end

  logic [16:0]        u9_r, v9_r;
  logic               par9_r;
  logic [23:0]        n9_r;
  logic [31:0]        sq9_r;
  logic signed [33:0] mix9_r;

  always_ff @(posedge clk) begin
    if (en) begin
      u9_r   <= u8;
      v9_r   <= v8;
      par9_r <= par8;
      n9_r   <= n8;
      sq9_r  <= 32'(su8 + sv8);
      mix9_r <= mix8;
    end
  end

  // ---------------- stages 10..13: radial distance ----------------
  logic [15:0] root13;

  pmg_sqrt u_sqrt (.clk(clk), .en(en), .a(sq9_r), .root(root13));

  // ---------------- stage 10: simple presets, mix reciprocal ----------------
  logic [33:0] mix_bias;
  logic [20:0] mix_a;
  logic [16:0] pre9;

  assign mix_bias = 34'(mix9_r + 34'sd12800);
  assign mix_a    = mix_bias[30:10];

  always_comb begin
    case (preset)
      pmg_pkg::PRESET_LIN_X:   pre9 = u9_r;
      pmg_pkg::PRESET_LIN_Y:   pre9 = v9_r;
      pmg_pkg::PRESET_CHECKER: pre9 = par9_r ? pmg_pkg::ONE_Q16 : 17'd0;
      pmg_pkg::PRESET_NOISE:   pre9 = 17'((25'(n9_r) + 25'd128) >> 8);
      default:                 pre9 = 17'd0;
    endcase
  end

  logic [16:0] pre10_r;
  logic        mpos10_r;
  logic [43:0] prod10_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pre10_r  <= pre9;
      mpos10_r <= (mix9_r > 34'sd0);
      prod10_r <= 44'(mix_a) * 44'(pmg_pkg::MIX_RECIP);
    end
  end

  // ---------------- stage 11: finish mix presets, clamp ----------------
  logic [16:0] mixq10, val10;
  assign mixq10 = prod10_r[pmg_pkg::MIX_SHIFT +: 17];

  always_comb begin
    if (preset == pmg_pkg::PRESET_EDGE || preset == pmg_pkg::PRESET_DIRT) begin
      if (!mpos10_r) begin
        val10 = 17'd0;
      end else begin
        val10 = (mixq10 > pmg_pkg::ONE_Q16) ? pmg_pkg::ONE_Q16 : mixq10;
      end
    end else begin
      val10 = pre10_r;
    end
  end

  // Hold the value through stages 11..13 to meet the square root
  logic [16:0] vd_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      vd_r[0] <= val10;
      vd_r[1] <= vd_r[0];
      vd_r[2] <= vd_r[1];
    end
  end

  // ---------------- stage 14: radial select, contrast multiply ----------------
  logic signed [17:0] rad13;
  logic [16:0]        value13;
  logic signed [17:0] dev13;
  logic signed [35:0] d14_r;

  assign rad13   = 18'sd65536 - $signed({1'b0, root13, 1'b0});
  always_comb begin
    if (preset == pmg_pkg::PRESET_RADIAL) begin
      value13 = rad13[17] ? 17'd0 : rad13[16:0];
    end else begin
      value13 = vd_r[2];
    end
  end
  assign dev13 = $signed({1'b0, value13}) - 18'sd32768;

  always_ff @(posedge clk) begin
    if (en) begin
      d14_r <= dev13 * $signed({1'b0, s_sat});
    end
  end

  // ---------------- stage 15: recenter, clamp, scale to a byte ----------------
  logic signed [35:0] t14;
  logic [32:0]        tc14;
  logic [40:0]        scaled14;
  logic [7:0]         out_r;

  assign t14 = d14_r + 36'sd2147483648;
  always_comb begin
    if (t14 < 36'sd0) begin
      tc14 = 33'd0;
    end else if (t14 > 36'sd4294967296) begin
      tc14 = 33'h1_0000_0000;
    end else begin
      tc14 = t14[32:0];
    end
  end
  // t*255 as t*256 - t, plus half for rounding
  assign scaled14 = {tc14, 8'b0} - 41'(tc14) + 41'h0_8000_0000;

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= scaled14[39:32];
    end
  end

  assign out_tdata = out_r;

  // ---------------- assertions ----------------
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> vld_r[0])
    else $error("accepted transaction did not enter stage 0");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("valid chain moved during a stall");

  a_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
    (en && vld_r[LAST-1]) |=> out_tvalid)
    else $error("transaction lost before the output register");

endmodule

@@ hdl/pmg_div.sv @@
module pmg_div #(
  parameter int NUM_W  = 31,
  parameter int DEN_W  = 15,
  parameter int STAGES = 8
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quo
);

  localparam int BPS   = (NUM_W + STAGES - 1) / STAGES;
  localparam int PAD_W = BPS * STAGES;

  logic [DEN_W:0]   rem_r [STAGES];
  logic [PAD_W-1:0] sh_r  [STAGES];

  // Restoring division: numerator bits shift out the top, quotient bits in the bottom
  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    logic [DEN_W:0]   rem_in, rem_nxt;
    logic [PAD_W-1:0] sh_in, sh_nxt;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign sh_in  = PAD_W'(num);
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign sh_in  = sh_r[k-1];
    end

    always_comb begin
      logic [DEN_W:0] r2;
      rem_nxt = rem_in;
      sh_nxt  = sh_in;
      for (int b = 0; b < BPS; b++) begin
        r2     = {rem_nxt[DEN_W-1:0], sh_nxt[PAD_W-1]};
        sh_nxt = {sh_nxt[PAD_W-2:0], 1'b0};
        if (r2 >= {1'b0, den}) begin
          rem_nxt   = r2 - {1'b0, den};
          sh_nxt[0] = 1'b1;
        end else begin
          rem_nxt = r2;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        sh_r[k]  <= sh_nxt;
      end
    end
  end

  assign quo = sh_r[STAGES-1][NUM_W-1:0];

endmodule

@@ hdl/pmg_sqrt.sv @@
module pmg_sqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  output logic [15:0] root
);

  logic [19:0] rem_r  [pmg_pkg::SQ_STAGES];
  logic [15:0] root_r [pmg_pkg::SQ_STAGES];
  logic [31:0] sh_r   [pmg_pkg::SQ_STAGES];

  // Digit-by-digit square root, two radicand bits per result bit
  for (genvar k = 0; k < pmg_pkg::SQ_STAGES; k++) begin : g_stage
    logic [19:0] rem_in, rem_nxt;
    logic [15:0] root_in, root_nxt;
    logic [31:0] sh_in, sh_nxt;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign sh_in   = a;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign sh_in   = sh_r[k-1];
    end

    always_comb begin
      logic [19:0] r2;
      logic [19:0] trial;
      rem_nxt  = rem_in;
      root_nxt = root_in;
      sh_nxt   = sh_in;
      for (int b = 0; b < pmg_pkg::SQ_STEPS; b++) begin
        r2     = {rem_nxt[17:0], sh_nxt[31:30]};
        sh_nxt = {sh_nxt[29:0], 2'b00};
        trial  = {2'b00, root_nxt, 2'b01};
        if (r2 >= trial) begin
          rem_nxt  = r2 - trial;
          root_nxt = {root_nxt[14:0], 1'b1};
        end else begin
          rem_nxt  = r2;
          root_nxt = {root_nxt[14:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
        sh_r[k]   <= sh_nxt;
      end
    end
  end

  assign root = root_r[pmg_pkg::SQ_STAGES-1];

endmodule

@@ hdl/pmg_hash.sv @@
module pmg_hash (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] x,
  input  logic [31:0] y,
  input  logic [31:0] seed,
  output logic [23:0] n
);

  logic [31:0] px_r, py_r, ps_r;
  logic [31:0] hx_r;
  logic [31:0] m_r;
  logic [23:0] n_r;
  logic [31:0] h_sum;

  assign h_sum = px_r + py_r + ps_r;

  always_ff @(posedge clk) begin
    if (en) begin
      px_r <= 32'(x * pmg_pkg::HASH_MUL_X);
      py_r <= 32'(y * pmg_pkg::HASH_MUL_Y);
      ps_r <= 32'(seed * pmg_pkg::HASH_MUL_S);
      hx_r <= h_sum ^ (h_sum >> 13);
      m_r  <= 32'(hx_r * pmg_pkg::HASH_MUL_MIX);
      n_r  <= 24'(m_r ^ (m_r >> 16));
    end
  end

  assign n = n_r;

endmodule
